### rtl/core/uso_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package uso_pkg;

  localparam int VOICES      = 7;
  localparam int RATIO_COUNT = 7;
  localparam int PHASE_W     = 32;
  localparam int RATIO_W     = 17;
  localparam int FRAC_W      = 16;
  localparam int SAW_W       = 8;
  localparam int MIX_W       = 12;
  localparam int LEVEL_W     = 8;

  localparam logic [PHASE_W-1:0] SEED = 32'h2545_F491;

  localparam logic [RATIO_W-1:0] DETUNE_Q16 [RATIO_COUNT] = '{
    17'd63668, 17'd64691, 17'd65195, 17'd65536, 17'd65877, 17'd66395, 17'd67456
  };

  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_NOTE_ON  = 2'd1,
    OP_NOTE_OFF = 2'd2
  } uso_op_t;

  typedef enum logic [1:0] {
    STAGE_IDLE    = 2'd0,
    STAGE_ATTACK  = 2'd1,
    STAGE_SUSTAIN = 2'd2,
    STAGE_RELEASE = 2'd3
  } uso_stage_t;

  typedef struct packed {
    logic note_on;
    logic tick;
  } uso_voice_ctl_t;

  function automatic logic [PHASE_W-1:0] xorshift32(input logic [PHASE_W-1:0] x);
    logic [PHASE_W-1:0] a;
    logic [PHASE_W-1:0] b;
    a = x ^ (x << 13);
    b = a ^ (a >> 17);
    return b ^ (b << 5);
  endfunction

endpackage
`default_nettype wire

### rtl/core/unison_saw_oscillator_envelope.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel  Dir  Transfer             Payload
// in_      in   tvalid & tready      tuser: operation; tdata: base_increment
// out_     out  tvalid & tready      tdata: mix_sample, envelope_level, envelope_stage
// cfg_     in   cfg_we               cfg_wdata: envelope_step
//
// One item per cycle sustained while out_ does not stall; each passes the input and result registers.
// The input register feeds the envelope and the seven voice lanes (one 32x17 multiplier
// and one phase adder per lane); state and the result register update on the same edge.
// Reset: synchronous, active low; no clearing pass.
// A stalled out_ holds the input register; in_tready falls only when both stages are full.
module unison_saw_oscillator_envelope
  import uso_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] base_increment
  input  wire logic [1:0]  in_tuser,   // [1:0] operation
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // [11:0] mix_sample, [19:12] envelope_level,
                                       // [21:20] envelope_stage, [23:22] zero
  input  wire logic        cfg_we,
  input  wire logic [7:0]  cfg_wdata
);

  logic                     in_valid_r;
  uso_op_t                  in_op_r;
  logic [PHASE_W-1:0]       in_base_r;
  logic                     advance;
  logic                     env_active;
  uso_stage_t               stage_nxt;
  logic [LEVEL_W-1:0]       level_nxt;
  logic signed [MIX_W-1:0]  mix;
  uso_voice_ctl_t           voice_ctl;
  logic                     out_valid_r;
  logic [MIX_W-1:0]         out_mix_r;
  logic [LEVEL_W-1:0]       out_level_r;
  uso_stage_t               out_stage_r;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_op_r   <= uso_op_t'(in_tuser);
      in_base_r <= in_tdata;
    end
  end

  uso_envelope u_env (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .fire      (advance),
    .op        (in_op_r),
    .active    (env_active),
    .stage_nxt (stage_nxt),
    .level_nxt (level_nxt)
  );

  assign voice_ctl.note_on = advance && (in_op_r == OP_NOTE_ON);
  assign voice_ctl.tick    = advance && (in_op_r == OP_TICK) && env_active;

  uso_voice_bank u_voices (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctl            (voice_ctl),
    .base_increment (in_base_r),
    .mix            (mix)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_mix_r   <= mix;
      out_level_r <= level_nxt;
      out_stage_r <= stage_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_stage_r, out_level_r, out_mix_r};

  a_sustain_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_stage_r == STAGE_SUSTAIN) |-> (out_level_r == '1))
    else $error("sustain reported below full level");

  a_idle_silent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_stage_r == STAGE_IDLE) |-> (out_level_r == '0))
    else $error("idle reported with nonzero level");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_valid_r && !out_tready && in_valid_r))
    else $error("input stalled without a blocked result");

endmodule
`default_nettype wire

### rtl/core/uso_envelope.sv
`timescale 1ns / 1ps
`default_nettype none
module uso_envelope
  import uso_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [LEVEL_W-1:0] cfg_wdata,
  input  wire logic               fire,
  input  wire uso_op_t            op,
  output logic                    active,
  output uso_stage_t              stage_nxt,
  output logic [LEVEL_W-1:0]      level_nxt
);

  logic [LEVEL_W-1:0] step_r;
  uso_stage_t         stage_r;
  logic [LEVEL_W-1:0] level_r;
  logic [LEVEL_W:0]   attack_sum;

  assign active     = (stage_r != STAGE_IDLE);
  assign attack_sum = {1'b0, level_r} + {1'b0, step_r};

  always_comb begin
    stage_nxt = stage_r;
    level_nxt = level_r;
    if (fire) begin
      case (op)
        OP_NOTE_ON:  stage_nxt = STAGE_ATTACK;
        OP_NOTE_OFF: stage_nxt = STAGE_RELEASE;
        OP_TICK: begin
          if (stage_r == STAGE_ATTACK) begin
            if (attack_sum[LEVEL_W]) begin
              level_nxt = '1;
              stage_nxt = STAGE_SUSTAIN;
            end else begin
              level_nxt = attack_sum[LEVEL_W-1:0];
            end
          end else if (stage_r == STAGE_RELEASE) begin
            if (step_r > level_r) begin
              level_nxt = '0;
              stage_nxt = STAGE_IDLE;
            end else begin
              level_nxt = level_r - step_r;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= LEVEL_W'(1);
      stage_r <= STAGE_IDLE;
      level_r <= '0;
    end else begin
      if (cfg_we) begin
        step_r <= cfg_wdata;
      end
      stage_r <= stage_nxt;
      level_r <= level_nxt;
    end
  end

endmodule
`default_nettype wire

### rtl/core/uso_voice_bank.sv
`timescale 1ns / 1ps
`default_nettype none
module uso_voice_bank
  import uso_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire uso_voice_ctl_t      ctl,
  input  wire logic [PHASE_W-1:0]  base_increment,
  output logic signed [MIX_W-1:0]  mix
);

  logic [PHASE_W-1:0] phase_r [VOICES];
  logic [PHASE_W-1:0] inc_r   [VOICES];
  logic [PHASE_W-1:0] inc_nxt [VOICES];
  logic [PHASE_W-1:0] rnd     [VOICES+1];
  logic [PHASE_W-1:0] lfsr_r;
  logic signed [MIX_W-2:0] sum;

  assign rnd[0] = lfsr_r;

  for (genvar i = 0; i < VOICES; i++) begin : g_voice
    localparam int R = (i < RATIO_COUNT) ? i : RATIO_COUNT - 1;
    logic [PHASE_W+RATIO_W-1:0] prod;

    assign rnd[i+1]   = xorshift32(rnd[i]);
    assign prod       = {{RATIO_W{1'b0}}, base_increment} * {{PHASE_W{1'b0}}, DETUNE_Q16[R]};
    assign inc_nxt[i] = prod[FRAC_W +: PHASE_W];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        phase_r[i] <= '0;
        inc_r[i]   <= '0;
      end else if (ctl.note_on) begin
        phase_r[i] <= rnd[i+1];
        inc_r[i]   <= inc_nxt[i];
      end else if (ctl.tick) begin
        phase_r[i] <= phase_r[i] + inc_r[i];
      end
    end
  end

  always_comb begin
    logic signed [SAW_W-1:0] saw;
    sum = '0;
    for (int i = 0; i < VOICES; i++) begin
      saw = $signed({~phase_r[i][PHASE_W-1], phase_r[i][PHASE_W-2 -: SAW_W-1]});
      sum = sum + (MIX_W-1)'(saw);
    end
  end

  assign mix = ctl.tick ? {sum, 1'b0} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lfsr_r <= SEED;
    end else if (ctl.note_on) begin
      lfsr_r <= rnd[VOICES];
    end
  end

endmodule
`default_nettype wire
